[design/rap_pkg.sv]
`timescale 1ns / 1ps
package rap_pkg;

  // Field widths
  localparam int IN_W       = 16;             // Q1.15 inputs and sine/cosine registers
  localparam int FRAC       = 15;             // fraction bits of one Q1.15 factor
  localparam int W_W        = 13;             // image width register
  localparam int Q_W        = 13;             // screen coordinate
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = IN_W;

  // Datapath widths
  localparam int P_W   = 2 * IN_W;            // one 16x16 product
  localparam int T_W   = P_W + 1;             // sum or difference of two products
  localparam int ROT_W = T_W + FRAC;          // rotated component, Q.45
  localparam int D_W   = ROT_W + 1;           // depth term 2^45 + y' and offsets
  localparam int DEN_W = D_W;                 // divisor 2*D
  localparam int NUM_W = D_W + W_W + 1;       // signed numerator
  localparam int REM_W = NUM_W - 1;           // non-negative numerator / remainder

  // Constants
  localparam logic signed [D_W-1:0] ONE_D     = D_W'(64'd1 << (3 * FRAC));
  localparam logic signed [7:0]     MARGIN2   = 8'sd60;   // twice the 30-pixel margin
  localparam logic [Q_W-1:0]        COORD_MAX = {Q_W{1'b1}};

  localparam logic [IN_W-1:0] RST_COS   = 16'd32767;
  localparam logic [IN_W-1:0] RST_SIN   = 16'd0;
  localparam logic [W_W-1:0]  RST_IMG_W = 13'd1280;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_COS_AZ = 3'd0,
    CFG_SIN_AZ = 3'd1,
    CFG_COS_HT = 3'd2,
    CFG_SIN_HT = 3'd3,
    CFG_IMG_W  = 3'd4
  } cfg_idx_e;

  typedef struct packed {
    logic [IN_W-1:0] cos_az;
    logic [IN_W-1:0] sin_az;
    logic [IN_W-1:0] cos_ht;
    logic [IN_W-1:0] sin_ht;
    logic [W_W-1:0]  img_w;
  } cfg_t;

  typedef struct packed {
    logic             valid;
    logic [ROT_W-1:0] rx;
    logic [ROT_W-1:0] ry;
    logic [ROT_W-1:0] rz;
  } rot_t;

  typedef struct packed {
    logic             valid;
    logic             vis;
    logic [NUM_W-1:0] num;
    logic [DEN_W-1:0] den;
  } div_in_t;

  typedef struct packed {
    logic           valid;
    logic           vis;
    logic [Q_W-1:0] q;
  } div_out_t;

endpackage

[design/rap_if.sv]
`timescale 1ns / 1ps
interface rap_in_if import rap_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [IN_W-1:0] dir_x;
  logic [IN_W-1:0] dir_y;
  logic [IN_W-1:0] dir_z;

  modport source (output valid, output dir_x, output dir_y, output dir_z, input ready);
  modport sink   (input valid, input dir_x, input dir_y, input dir_z, output ready);
endinterface

interface rap_out_if import rap_pkg::*; ();
  logic           valid;
  logic           ready;
  logic           visible;
  logic [Q_W-1:0] screen_x;
  logic [Q_W-1:0] screen_y;

  modport source (output valid, output visible, output screen_x, output screen_y,
                  input ready);
  modport sink   (input valid, input visible, input screen_x, input screen_y,
                  output ready);
endinterface

[design/rap_rotate.sv]
`timescale 1ns / 1ps
module rap_rotate import rap_pkg::*; (
  input  logic            clk,
  input  logic            rst,
  input  logic            en,
  input  logic            in_valid,
  input  logic [IN_W-1:0] dir_x,
  input  logic [IN_W-1:0] dir_y,
  input  logic [IN_W-1:0] dir_z,
  input  cfg_t            cfg,
  output rot_t            rot
);

  logic signed [IN_W-1:0] px, py, pz, ca, sa, ch, sh;

  // stage A: shared products t = px*sa + py*ca, u = px*ca - py*sa
  logic                  a_valid;
  logic signed [T_W-1:0] a_t, a_u;
  logic signed [P_W-1:0] a_pzsh, a_pzch;

  // stage B: rotated vector in Q.45
  logic                    b_valid;
  logic signed [ROT_W-1:0] b_rx, b_ry, b_rz;
  logic signed [ROT_W-1:0] ch_t, sh_t, pzsh_s, pzch_s;

  assign px = $signed(dir_x);
  assign py = $signed(dir_y);
  assign pz = $signed(dir_z);
  assign ca = $signed(cfg.cos_az);
  assign sa = $signed(cfg.sin_az);
  assign ch = $signed(cfg.cos_ht);
  assign sh = $signed(cfg.sin_ht);

  // advance valid bits with the pipeline
  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
      b_valid <= 1'b0;
    end else if (en) begin
      a_valid <= in_valid;
      b_valid <= a_valid;
    end
  end

  // stage A payload
  always_ff @(posedge clk) begin
    if (en) begin
      a_t    <= px * sa + py * ca;
      a_u    <= px * ca - py * sa;
      a_pzsh <= pz * sh;
      a_pzch <= pz * ch;
    end
  end

  // y' = ch*t + sh*pz*2^15, z' = ch*pz*2^15 - sh*t, x' = u*2^15
  assign ch_t   = ch * a_t;
  assign sh_t   = sh * a_t;
  assign pzsh_s = {a_pzsh[P_W-1], a_pzsh, {FRAC{1'b0}}};
  assign pzch_s = {a_pzch[P_W-1], a_pzch, {FRAC{1'b0}}};

  always_ff @(posedge clk) begin
    if (en) begin
      b_rx <= {a_u, {FRAC{1'b0}}};
      b_ry <= ch_t + pzsh_s;
      b_rz <= pzch_s - sh_t;
    end
  end

  assign rot = '{valid: b_valid, rx: b_rx, ry: b_ry, rz: b_rz};

endmodule

[design/rap_project.sv]
`timescale 1ns / 1ps
module rap_project import rap_pkg::*; (
  input  logic           clk,
  input  logic           rst,
  input  logic           en,
  input  rot_t           rot,
  input  logic [W_W-1:0] img_w,
  output div_in_t        xd,
  output div_in_t        yd
);

  logic signed [ROT_W-1:0] rx_s, ry_s, rz_s;
  logic signed [D_W-1:0]   d_c;
  logic signed [W_W:0]     ws;

  // stage C: depth D and the two offset terms
  logic                  c_valid, c_vis;
  logic signed [D_W-1:0] c_d, c_ex, c_ey;

  // stage D: scale by image width
  logic                    d_valid, d_vis;
  logic signed [NUM_W-1:0] d_px, d_py, d_60;
  logic [DEN_W-1:0]        d_den;

  // stage E: numerators
  logic                    e_valid, e_vis;
  logic signed [NUM_W-1:0] e_numx, e_numy;
  logic [DEN_W-1:0]        e_den;

  assign rx_s = $signed(rot.rx);
  assign ry_s = $signed(rot.ry);
  assign rz_s = $signed(rot.rz);
  assign d_c  = ONE_D + D_W'(ry_s);
  assign ws   = $signed({1'b0, img_w});

  // advance valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      c_valid <= 1'b0;
      d_valid <= 1'b0;
      e_valid <= 1'b0;
    end else if (en) begin
      c_valid <= rot.valid;
      d_valid <= c_valid;
      e_valid <= d_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c_vis  <= ry_s > 0;
      c_d    <= d_c;
      c_ex   <= d_c + D_W'(rx_s);
      c_ey   <= d_c - D_W'(rz_s);

      d_vis  <= c_vis;
      d_px   <= ws * c_ex;
      d_py   <= ws * c_ey;
      d_60   <= c_d * MARGIN2;
      d_den  <= {c_d[D_W-2:0], 1'b0};

      e_vis  <= d_vis;
      e_numx <= d_60 + d_px;
      e_numy <= d_60 + d_py;
      e_den  <= d_den;
    end
  end

  assign xd = '{valid: e_valid, vis: e_vis, num: e_numx, den: e_den};
  assign yd = '{valid: e_valid, vis: e_vis, num: e_numy, den: e_den};

endmodule

[design/rap_divider.sv]
`timescale 1ns / 1ps
module rap_divider import rap_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     en,
  input  div_in_t  din,
  output div_out_t dout
);

  // stage 0 checks the clip cases, stages 1..Q_W each resolve one quotient bit
  logic [Q_W:0]     st_valid;
  logic [Q_W:0]     st_vis;
  logic [Q_W:0]     st_zero;
  logic [Q_W:0]     st_sat;
  logic [REM_W-1:0] st_rem [0:Q_W];
  logic [DEN_W-1:0] st_den [0:Q_W];
  logic [Q_W-1:0]   st_q   [0:Q_W];

  logic             o_valid, o_vis;
  logic [Q_W-1:0]   o_q;

  // stage 0: negative numerator or hidden point clips to zero, large quotient saturates
  always_ff @(posedge clk) begin
    if (rst) begin
      st_valid[0] <= 1'b0;
    end else if (en) begin
      st_valid[0] <= din.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      st_vis[0]  <= din.vis;
      st_zero[0] <= !din.vis || din.num[NUM_W-1];
      st_sat[0]  <= din.num[REM_W-1:0] >= {din.den, {Q_W{1'b0}}};
      st_rem[0]  <= din.num[REM_W-1:0];
      st_den[0]  <= din.den;
      st_q[0]    <= '0;
    end
  end

  // restoring steps, most significant quotient bit first
  for (genvar k = 0; k < Q_W; k++) begin : g_step
    localparam int SH = Q_W - 1 - k;
    logic [REM_W-1:0] trial;
    logic             fits;

    assign trial = REM_W'(st_den[k]) << SH;
    assign fits  = st_rem[k] >= trial;

    always_ff @(posedge clk) begin
      if (rst) begin
        st_valid[k+1] <= 1'b0;
      end else if (en) begin
        st_valid[k+1] <= st_valid[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        st_vis[k+1]      <= st_vis[k];
        st_zero[k+1]     <= st_zero[k];
        st_sat[k+1]      <= st_sat[k];
        st_den[k+1]      <= st_den[k];
        st_rem[k+1]      <= fits ? st_rem[k] - trial : st_rem[k];
        st_q[k+1]        <= st_q[k] | (Q_W'(fits) << SH);
      end
    end
  end

  // output stage: apply clipping
  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
    end else if (en) begin
      o_valid <= st_valid[Q_W];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      o_vis <= st_vis[Q_W];
      if (st_zero[Q_W]) begin
        o_q <= '0;
      end else if (st_sat[Q_W]) begin
        o_q <= COORD_MAX;
      end else begin
        o_q <= st_q[Q_W];
      end
    end
  end

  assign dout = '{valid: o_valid, vis: o_vis, q: o_q};

  // an in-range quotient leaves a remainder below the divisor
  a_rem_below_den: assert property (@(posedge clk) disable iff (rst)
    st_valid[Q_W] && !st_zero[Q_W] && !st_sat[Q_W] |->
      st_rem[Q_W] < REM_W'(st_den[Q_W]))
    else $error("divider remainder not below divisor");

endmodule

[design/rotate_and_project_point.sv]
`timescale 1ns / 1ps
// Channel   Dir  Handshake          Beat payload
// dir       in   valid/ready        dir_x, dir_y, dir_z (Q1.15 signed)
// scr       out  valid/ready        visible, screen_x, screen_y (13 bits)
// cfg       in   cfg_we (no ready)  cfg_index, cfg_data
//
// One beat accepted per cycle unless a result is held at scr.
// The pipeline runs 2 rotation stages, 3 projection stages and the clip check stage,
// then the 13-stage restoring divider, one quotient bit per stage,
// followed by the clip output stage.
// Reset clears every valid bit and loads the default view and image width.
// A result held at scr freezes the whole pipeline; dir.ready drops in the same cycle.
module rotate_and_project_point import rap_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  rap_in_if.sink                dir,
  rap_out_if.source             scr
);

  cfg_t     cfg;
  logic     en;
  rot_t     rot;
  div_in_t  x_in, y_in;
  div_out_t x_out, y_out;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '{cos_az: RST_COS, sin_az: RST_SIN, cos_ht: RST_COS, sin_ht: RST_SIN,
               img_w: RST_IMG_W};
    end else if (cfg_we) begin
      unique case (cfg_idx_e'(cfg_index))
        CFG_COS_AZ: cfg.cos_az <= cfg_data;
        CFG_SIN_AZ: cfg.sin_az <= cfg_data;
        CFG_COS_HT: cfg.cos_ht <= cfg_data;
        CFG_SIN_HT: cfg.sin_ht <= cfg_data;
        CFG_IMG_W:  cfg.img_w  <= cfg_data[W_W-1:0];
        default: ;
      endcase
    end
  end

  // advance the pipeline unless a finished result is waiting
  assign en        = !scr.valid || scr.ready;
  assign dir.ready = en;

  rap_rotate u_rotate (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (dir.valid),
    .dir_x    (dir.dir_x),
    .dir_y    (dir.dir_y),
    .dir_z    (dir.dir_z),
    .cfg      (cfg),
    .rot      (rot)
  );

  rap_project u_project (
    .clk   (clk),
    .rst   (rst),
    .en    (en),
    .rot   (rot),
    .img_w (cfg.img_w),
    .xd    (x_in),
    .yd    (y_in)
  );

  rap_divider u_div_x (
    .clk  (clk),
    .rst  (rst),
    .en   (en),
    .din  (x_in),
    .dout (x_out)
  );

  rap_divider u_div_y (
    .clk  (clk),
    .rst  (rst),
    .en   (en),
    .din  (y_in),
    .dout (y_out)
  );

  assign scr.valid    = x_out.valid;
  assign scr.visible  = x_out.vis;
  assign scr.screen_x = x_out.q;
  assign scr.screen_y = y_out.q;

  a_lanes_aligned: assert property (@(posedge clk) disable iff (rst)
    x_out.valid == y_out.valid && (!x_out.valid || x_out.vis == y_out.vis))
    else $error("coordinate lanes out of step");

  a_hidden_zero: assert property (@(posedge clk) disable iff (rst)
    scr.valid && !scr.visible |-> scr.screen_x == '0 && scr.screen_y == '0)
    else $error("hidden point with nonzero coordinates");

  a_stall_blocks_input: assert property (@(posedge clk) disable iff (rst)
    scr.valid && !scr.ready |-> !dir.ready)
    else $error("input taken while output stalled");

endmodule

[tb/rotate_and_project_point_test.sv]
`timescale 1ns / 1ps
module rotate_and_project_point_test;
  import rap_pkg::*;

  localparam int  PIPE_LATENCY = 20;
  localparam int  NUM_PHASES   = 9;
  localparam int  PHASE_ITEMS  = 100;
  localparam real DEG_TO_RAD   = 3.14159265358979 / 180.0;

  typedef struct packed {
    logic [IN_W-1:0] x;
    logic [IN_W-1:0] y;
    logic [IN_W-1:0] z;
  } dir_beat_t;

  typedef struct packed {
    logic           visible;
    logic [Q_W-1:0] screen_x;
    logic [Q_W-1:0] screen_y;
  } screen_point_t;

  typedef enum logic [1:0] {RX_FREE, RX_COIN, RX_PATTERN, RX_CHOKE} rx_style_e;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic                  dir_took = 1'b0;

  rap_in_if  dir_bus ();
  rap_out_if scr_bus ();

  rotate_and_project_point DUT (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .dir       (dir_bus.sink),
    .scr       (scr_bus.source)
  );

  // Local copy of the view registers
  logic signed [IN_W-1:0] view_cos_az = RST_COS;
  logic signed [IN_W-1:0] view_sin_az = RST_SIN;
  logic signed [IN_W-1:0] view_cos_ht = RST_COS;
  logic signed [IN_W-1:0] view_sin_ht = RST_SIN;
  logic        [W_W-1:0]  view_img_w  = RST_IMG_W;

  dir_beat_t     pending_dirs[$];
  screen_point_t expected_points[$];
  int            mismatch_count = 0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  task automatic flag_mismatch(input string what);
    $display("[%0t] MISMATCH: %s", $time, what);
    mismatch_count++;
  endtask

  // Truncate the projected coordinate toward zero and clamp to the screen range
  function automatic logic [Q_W-1:0] clip_coord(input longint d, input longint offset,
                                                input longint w);
    longint num;
    longint q;
    num = longint'(MARGIN2) * d + w * (d + offset);
    q = num / (2 * d);
    if (q < 0) q = 0;
    if (q > longint'(COORD_MAX)) q = longint'(COORD_MAX);
    return q[Q_W-1:0];
  endfunction

  // Rotate the direction by the view matrix, then project in perspective
  function automatic screen_point_t project_point(input dir_beat_t d);
    longint ca, sa, ch, sh, px, py, pz, one_frac, rx, ry, rz, depth;
    screen_point_t pt;
    ca = longint'(view_cos_az);
    sa = longint'(view_sin_az);
    ch = longint'(view_cos_ht);
    sh = longint'(view_sin_ht);
    px = longint'($signed(d.x));
    py = longint'($signed(d.y));
    pz = longint'($signed(d.z));
    one_frac = longint'(1) << FRAC;
    rx = px * (ca * one_frac) + py * (-sa * one_frac);
    ry = px * (ch * sa) + py * (ch * ca) + pz * (sh * one_frac);
    rz = px * (-sh * sa) + py * (-sh * ca) + pz * (ch * one_frac);
    pt = '0;
    if (ry > 0) begin
      depth = longint'(ONE_D) + ry;
      pt.visible  = 1'b1;
      pt.screen_x = clip_coord(depth, rx, longint'(view_img_w));
      pt.screen_y = clip_coord(depth, -rz, longint'(view_img_w));
    end
    return pt;
  endfunction

  function automatic logic [IN_W-1:0] to_q15(input real v);
    int t;
    t = $rtoi(v * 32767.0);
    return t[IN_W-1:0];
  endfunction

  function automatic logic [IN_W-1:0] edge_value();
    case ($urandom_range(0, 4))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'h0000;
      3: return 16'h0001;
      default: return 16'hFFFF;
    endcase
  endfunction

  // Unit directions over the whole sphere for 45 of 100 picks, plus raw, tiny and edge values
  function automatic dir_beat_t random_dir();
    real az, el;
    int pick;
    dir_beat_t d;
    pick = $urandom_range(0, 99);
    if (pick < 45) begin
      az = $itor($urandom_range(0, 35999)) * DEG_TO_RAD / 100.0;
      el = ($itor($urandom_range(0, 18000)) - 9000.0) * DEG_TO_RAD / 100.0;
      d.x = to_q15($cos(el) * $sin(az));
      d.y = to_q15($cos(el) * $cos(az));
      d.z = to_q15($sin(el));
    end else if (pick < 75) begin
      d.x = IN_W'($urandom);
      d.y = IN_W'($urandom);
      d.z = IN_W'($urandom);
    end else if (pick < 90) begin
      d.x = IN_W'($signed(10'($urandom)));
      d.y = IN_W'($signed(10'($urandom)));
      d.z = IN_W'($signed(10'($urandom)));
    end else begin
      d.x = edge_value();
      d.y = edge_value();
      d.z = edge_value();
    end
    return d;
  endfunction

  task automatic write_view_reg(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_COS_AZ: view_cos_az = data;
      CFG_SIN_AZ: view_sin_az = data;
      CFG_COS_HT: view_cos_ht = data;
      CFG_SIN_HT: view_sin_ht = data;
      CFG_IMG_W:  view_img_w  = data[W_W-1:0];
      default: ;
    endcase
  endtask

  task automatic apply_view(input logic [IN_W-1:0] ca, input logic [IN_W-1:0] sa,
                            input logic [IN_W-1:0] ch, input logic [IN_W-1:0] sh,
                            input logic [CFG_DATA_W-1:0] w_data);
    write_view_reg(CFG_COS_AZ, ca);
    write_view_reg(CFG_SIN_AZ, sa);
    // a write to a spare index must leave the view untouched
    write_view_reg(CFG_IDX_W'($urandom_range(int'(CFG_IMG_W) + 1, (1 << CFG_IDX_W) - 1)),
                   CFG_DATA_W'($urandom));
    write_view_reg(CFG_COS_HT, ch);
    write_view_reg(CFG_SIN_HT, sh);
    write_view_reg(CFG_IMG_W, w_data);
  endtask

  // Hold until every queued beat is taken and every result is back
  task automatic wait_drained();
    do @(posedge clk);
    while (pending_dirs.size() != 0 || dir_bus.valid || expected_points.size() != 0);
  endtask

  // Sender: bursts of beats separated by random gaps
  int gap_left   = 0;
  int burst_left = 0;
  always @(negedge clk) begin
    if (rst) begin
      dir_bus.valid <= 1'b0;
    end else if (!dir_bus.valid || dir_took) begin
      if (gap_left > 0 || pending_dirs.size() == 0) begin
        dir_bus.valid <= 1'b0;
        if (gap_left > 0) gap_left--;
      end else begin
        dir_beat_t d;
        d = pending_dirs.pop_front();
        dir_bus.valid <= 1'b1;
        dir_bus.dir_x <= d.x;
        dir_bus.dir_y <= d.y;
        dir_bus.dir_z <= d.z;
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(1, 40);
          gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
        end
      end
    end
  end

  // Receiver: switch between stall styles after spans of random length
  rx_style_e rx_style = RX_FREE;
  int        rx_span  = 0;
  int        rx_tick  = 0;
  always @(negedge clk) begin
    if (rst) begin
      scr_bus.ready <= 1'b0;
    end else begin
      rx_tick++;
      if (rx_span == 0) begin
        rx_span = $urandom_range(20, 120);
        case ($urandom_range(0, 3))
          0: rx_style = RX_FREE;
          1: rx_style = RX_COIN;
          2: rx_style = RX_PATTERN;
          default: rx_style = RX_CHOKE;
        endcase
      end else begin
        rx_span--;
      end
      case (rx_style)
        RX_FREE:    scr_bus.ready <= 1'b1;
        RX_COIN:    scr_bus.ready <= 1'($urandom);
        RX_PATTERN: scr_bus.ready <= 1'(16'b1011_0010_1110_0110 >> (rx_tick % 16));
        default:    scr_bus.ready <= (rx_tick % 24) >= 20;
      endcase
    end
  end

  // Predict on every accepted direction beat, check every accepted result beat
  always @(posedge clk) begin : watch_beats
    screen_point_t want;
    if (rst) begin
      dir_took <= 1'b0;
    end else begin
      dir_took <= dir_bus.valid && dir_bus.ready;
      if (scr_bus.valid && scr_bus.ready) begin
        if (expected_points.size() == 0) begin
          flag_mismatch("result beat with no result expected");
        end else begin
          want = expected_points.pop_front();
          if (scr_bus.visible !== want.visible)
            flag_mismatch($sformatf("visible got %b want %b", scr_bus.visible, want.visible));
          if (scr_bus.screen_x !== want.screen_x)
            flag_mismatch($sformatf("screen_x got %0d want %0d",
                                    scr_bus.screen_x, want.screen_x));
          if (scr_bus.screen_y !== want.screen_y)
            flag_mismatch($sformatf("screen_y got %0d want %0d",
                                    scr_bus.screen_y, want.screen_y));
        end
      end
      if (dir_bus.valid && dir_bus.ready)
        expected_points.push_back(project_point({dir_bus.dir_x, dir_bus.dir_y,
                                                 dir_bus.dir_z}));
    end
  end

  initial begin
    #5ms;
    $display("rotate_and_project_point verification failed");
    $finish;
  end

  initial begin
    cfg_we        = 1'b0;
    cfg_index     = '0;
    cfg_data      = '0;
    dir_bus.valid = 1'b0;
    dir_bus.dir_x = '0;
    dir_bus.dir_y = '0;
    dir_bus.dir_z = '0;
    scr_bus.ready = 1'b0;
    repeat (2) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    // Directed beats under the reset view
    pending_dirs.push_back('{16'h0000, 16'h0000, 16'h0000});  // zero depth, hidden
    pending_dirs.push_back('{16'h0000, 16'h7FFF, 16'h0000});  // dead ahead
    pending_dirs.push_back('{16'h0000, 16'h0001, 16'h0000});  // barely in front
    pending_dirs.push_back('{16'h0000, 16'hFFFF, 16'h0000});  // barely behind
    pending_dirs.push_back('{16'h0000, 16'h8000, 16'h0000});  // straight behind
    pending_dirs.push_back('{16'h7FFF, 16'h7FFF, 16'h7FFF});
    pending_dirs.push_back('{16'h8000, 16'h8000, 16'h8000});
    pending_dirs.push_back('{16'h8000, 16'h7FFF, 16'h8000});
    pending_dirs.push_back('{16'h7FFF, 16'h7FFF, 16'h8000});
    pending_dirs.push_back('{16'h7FFF, 16'h0001, 16'h0000});  // right edge
    pending_dirs.push_back('{16'h8000, 16'h0001, 16'h7FFF});  // top left corner
    pending_dirs.push_back('{16'h8000, 16'h0001, 16'h8000});
    pending_dirs.push_back('{16'h7FFF, 16'h0001, 16'h7FFF});
    pending_dirs.push_back('{16'h5555, 16'h2AAA, 16'hAAAA});
    pending_dirs.push_back('{16'hAAAA, 16'h5555, 16'h5555});
    pending_dirs.push_back('{16'h5A82, 16'h5A82, 16'h0000});  // unit vector at 45 deg
    pending_dirs.push_back('{16'h0000, 16'h5A82, 16'hA57E});
    pending_dirs.push_back('{16'hFFFF, 16'hFFFF, 16'hFFFF});
    pending_dirs.push_back('{16'h0001, 16'h0001, 16'h0001});
    pending_dirs.push_back('{16'h8000, 16'h0000, 16'h7FFF});
    wait_drained();

    // Random beats over a series of views, extremes first
    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      real az, el;
      logic [CFG_DATA_W-1:0] w_data;
      az = $itor($urandom_range(0, 35999)) * DEG_TO_RAD / 100.0;
      el = ($itor($urandom_range(0, 18000)) - 9000.0) * DEG_TO_RAD / 100.0;
      case ($urandom_range(0, 3))
        0: w_data = {3'($urandom), 13'd1280};
        1: w_data = 16'd640;
        2: w_data = 16'($urandom_range(1, 8191));
        default: w_data = 16'($urandom_range(1, 64));
      endcase
      case (phase)
        0: apply_view(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'hFFFF);
        1: apply_view(16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h0000);
        2: apply_view(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0001);
        3: apply_view(IN_W'($urandom), IN_W'($urandom), IN_W'($urandom),
                      IN_W'($urandom), CFG_DATA_W'($urandom));
        4: apply_view(to_q15($cos(az)), to_q15($sin(az)), to_q15($cos(el)),
                      to_q15($sin(el)), 16'd8100);
        default: apply_view(to_q15($cos(az)), to_q15($sin(az)), to_q15($cos(el)),
                            to_q15($sin(el)), w_data);
      endcase
      for (int i = 0; i < PHASE_ITEMS; i++) pending_dirs.push_back(random_dir());
      wait_drained();
    end

    repeat (PIPE_LATENCY + 5) @(posedge clk);
    if (mismatch_count == 0)
      $display("rotate_and_project_point verification clean");
    else
      $display("rotate_and_project_point verification failed");
    $finish;
  end

endmodule
